/* rtl/core/lps_pkg.sv */
// Shared types, constants, pattern table and helpers of the LED pattern sequencer.
package lps_pkg;

    // Sizing of the engine.
    localparam int NUM_LEDS  = 6;
    localparam int NUM_SEQS  = 10;
    localparam int MAX_STEPS = 16;

    // Field widths on the stream ports.
    localparam int REQ_W     = 2;
    localparam int LED_W     = 3;
    localparam int SEQ_W     = 4;
    localparam int LEVEL_W   = 6;
    localparam int S_TDATA_W = 8;
    localparam int M_TDATA_W = 8;

    // Internal widths.
    localparam int LED_IDX_W   = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
    localparam int SEQ_IDX_W   = (NUM_SEQS > 1) ? $clog2(NUM_SEQS) : 1;
    localparam int LEVEL_IDX_W = $clog2(LEVEL_W);
    localparam int STEP_W      = 5;
    localparam int WAIT_W      = 10;
    localparam int ENTRY_W     = 12;
    localparam int ACT_W       = 11;

    // Step position store: one row of sixteen slots per LED.
    localparam int MEM_DEPTH  = NUM_LEDS << SEQ_W;
    localparam int MEM_ADDR_W = $clog2(MEM_DEPTH);

    // Bound on the steps of one execution run.
    localparam int GUARD_LIMIT = 2 * NUM_SEQS * MAX_STEPS;
    localparam int GUARD_W     = $clog2(GUARD_LIMIT + 1);

    // Command queue between front and back.
    localparam int FIFO_DEPTH = 2;

    // Request codes on the input channel.
    localparam logic [REQ_W-1:0] REQ_TICK = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RUN  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STOP = 2'd2;

    // Marker for an LED with no running sequence.
    localparam logic [SEQ_W-1:0] NONE_CODE = 4'd15;

    // Step actions.
    localparam logic [ACT_W-1:0] ACT_LOOP = 11'h7FE;
    localparam logic [ACT_W-1:0] ACT_STOP = 11'h7FF;

    // Pattern table entries: bit 11 is the level, bits 10..0 the action.
    localparam int ROM_SEQS    = 10;
    localparam int ROM_STEPS   = 16;
    localparam int ROM_STEP_W  = $clog2(ROM_STEPS);

    localparam logic [ENTRY_W-1:0] E_ON50   = 12'h832;
    localparam logic [ENTRY_W-1:0] E_OFF50  = 12'h032;
    localparam logic [ENTRY_W-1:0] E_ON500  = 12'h9F4;
    localparam logic [ENTRY_W-1:0] E_OFF500 = 12'h1F4;
    localparam logic [ENTRY_W-1:0] E_ON1000 = 12'hBE8;
    localparam logic [ENTRY_W-1:0] E_OFF950 = 12'h3B6;
    localparam logic [ENTRY_W-1:0] E_LOOP   = 12'h7FE;
    localparam logic [ENTRY_W-1:0] E_STOP0  = 12'h7FF;
    localparam logic [ENTRY_W-1:0] E_STOP1  = 12'hFFF;

    localparam logic [ENTRY_W-1:0] PATTERN_ROM [ROM_SEQS][ROM_STEPS] = '{
        // Rapid flashes after a passed test.
        '{E_ON50, E_OFF50, E_ON50, E_OFF50, E_ON50, E_OFF50, E_ON50, E_OFF50,
          E_ON50, E_OFF50, E_ON50, E_OFF50, E_ON50, E_OFF50, E_STOP0, E_STOP0},
        // Low battery, steady on.
        '{E_ON1000, E_LOOP, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // Power on, then stay on.
        '{E_ON1000, E_STOP1, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // Two flashes.
        '{E_ON500, E_OFF500, E_ON500, E_OFF500, E_STOP0, E_STOP0, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // One flash.
        '{E_ON500, E_OFF500, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // Three flashes.
        '{E_ON500, E_OFF500, E_ON500, E_OFF500, E_ON500, E_OFF500, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // Always on.
        '{E_ON1000, E_LOOP, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // Error, 1 Hz blink.
        '{E_ON500, E_OFF500, E_LOOP, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // Alive heartbeat.
        '{E_ON50, E_OFF950, E_LOOP, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0},
        // Three flashes that end with the LED on.
        '{E_OFF500, E_ON500, E_OFF500, E_ON500, E_OFF500, E_ON500, E_STOP1, E_STOP0,
          E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0, E_STOP0}
    };

    // Classified command kinds handed from front to back.
    typedef enum logic [1:0] {
        CMD_TICK,
        CMD_RUN,
        CMD_STOP,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t             kind;
        logic [LED_IDX_W-1:0]  led;
        logic [SEQ_W-1:0]      seq;
        logic                  accepted;
    } cmd_t;

    typedef logic [NUM_SEQS-1:0] seq_mask_t;

    // Lowest-numbered running sequence, or the none marker.
    function automatic logic [SEQ_W-1:0] first_running(seq_mask_t mask);
        logic [SEQ_W-1:0] result;
        result = NONE_CODE;
        for (int i = NUM_SEQS - 1; i >= 0; i--) begin
            if (mask[i]) begin
                result = SEQ_W'(i);
            end
        end
        return result;
    endfunction

    // Table lookup; anything past the stored table reads as a stop with level off.
    function automatic logic [ENTRY_W-1:0] rom_read(logic [SEQ_W-1:0] seq,
                                                   logic [STEP_W-1:0] step);
        logic [ENTRY_W-1:0] result;
        result = E_STOP0;
        if ((int'(seq) < ROM_SEQS) && (int'(step) < ROM_STEPS) &&
            (int'(step) < MAX_STEPS)) begin
            result = PATTERN_ROM[seq][step[ROM_STEP_W-1:0]];
        end
        return result;
    endfunction

endpackage

/* rtl/core/led_pattern_priority_sequencer.sv */
// Top level of the LED pattern sequencer: front end, command queue and step executor.
//
//  Channel   Direction  Payload
//  s_        in         tuser[1:0] req_type; tdata[2:0] led_index, [6:3] seq_id
//  m_        out        tdata[5:0] led_levels, [6] accepted
//
// A run or stop may execute steps of its own LED; a tick scans the LEDs in turn and executes
// steps on each expiring wait; all are paced by the single read port of the step position
// memory that the executor walks through.
// One result leaves per request, registered from the done state once the output register is free.
// Reset is synchronous on aresetn; no clearing pass, the block is ready at once.
// The two-entry queue keeps taking requests while the executor or m_ stalls, until it is full.
module led_pattern_priority_sequencer (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lps_pkg::S_TDATA_W-1:0] s_tdata,   // [2:0] led_index, [6:3] seq_id
    input  logic [lps_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lps_pkg::M_TDATA_W-1:0] m_tdata    // [5:0] led_levels, [6] accepted
);
    import lps_pkg::*;

    cmd_t push_cmd;
    cmd_t pop_cmd;
    logic push;
    logic pop;
    logic fifo_full;
    logic fifo_empty;

    // Request classification.
    lps_front u_front (
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .fifo_full (fifo_full),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    // Command queue.
    lps_fifo u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .full     (fifo_full),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (fifo_empty)
    );

    // Step execution and result register.
    lps_exec u_exec (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .fifo_empty (fifo_empty),
        .pop_cmd    (pop_cmd),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata)
    );

endmodule

/* rtl/core/lps_front.sv */
// Front end: takes request transfers and classifies them into commands.
module lps_front (
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [lps_pkg::S_TDATA_W-1:0] s_tdata,   // [2:0] led_index, [6:3] seq_id
    input  logic [lps_pkg::REQ_W-1:0]     s_tuser,   // [1:0] req_type
    input  logic                          fifo_full,
    output logic                          push,
    output lps_pkg::cmd_t                 push_cmd
);
    import lps_pkg::*;

    logic [LED_W-1:0] led_field;
    logic [SEQ_W-1:0] seq_field;
    logic             seq_ok;
    logic             led_ok;

    // A transfer is taken whenever the queue has room.
    assign s_tready  = !fifo_full;
    assign push      = s_tvalid && !fifo_full;
    assign led_field = s_tdata[LED_W-1:0];
    assign seq_field = s_tdata[LED_W+SEQ_W-1:LED_W];
    assign seq_ok    = int'(seq_field) < NUM_SEQS;
    assign led_ok    = int'(led_field) < NUM_LEDS;

    // Requests that change nothing are reduced to a no-op carrying the flag.
    always_comb begin
        push_cmd.led      = LED_IDX_W'(led_field);
        push_cmd.seq      = seq_field;
        push_cmd.accepted = 1'b1;
        push_cmd.kind     = CMD_NOP;
        unique case (s_tuser)
            REQ_TICK: begin
                push_cmd.kind = CMD_TICK;
            end
            REQ_RUN, REQ_STOP: begin
                if (!seq_ok) begin
                    push_cmd.accepted = 1'b0;
                end else if (led_ok) begin
                    push_cmd.kind = (s_tuser == REQ_RUN) ? CMD_RUN : CMD_STOP;
                end
            end
            default: begin
                push_cmd.kind = CMD_NOP;
            end
        endcase
    end

endmodule

/* rtl/core/lps_fifo.sv */
// Short command queue that decouples the front end from the step executor.
module lps_fifo (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  lps_pkg::cmd_t push_cmd,
    output logic          full,
    input  logic          pop,
    output lps_pkg::cmd_t pop_cmd,
    output logic          empty
);
    import lps_pkg::*;

    localparam int PTR_W = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int CNT_W = $clog2(FIFO_DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(FIFO_DEPTH - 1);

    cmd_t             slot_reg [FIFO_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_W'(FIFO_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_cmd = slot_reg[rd_ptr_reg];

    // Payload slots.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/lps_exec.sv */
// Back end: holds the per-LED sequence state and executes pattern steps.
module lps_exec (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          fifo_empty,
    input  lps_pkg::cmd_t                 pop_cmd,
    output logic                          pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [lps_pkg::M_TDATA_W-1:0] m_tdata    // [5:0] led_levels, [6] accepted
);
    import lps_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK_SCAN,
        ST_EX_SEL,
        ST_EX_RD,
        ST_DONE
    } state_t;

    localparam logic [LED_IDX_W-1:0] LAST_LED = LED_IDX_W'(NUM_LEDS - 1);

    state_t                  state_reg;
    seq_mask_t               running_reg [NUM_LEDS];
    logic [WAIT_W-1:0]       wait_reg [NUM_LEDS];
    logic [LEVEL_W-1:0]      level_reg;
    logic [LED_IDX_W-1:0]    cur_led_reg;
    logic [SEQ_W-1:0]        seq_reg;
    logic [GUARD_W-1:0]      guard_reg;
    logic                    tick_mode_reg;
    logic                    acc_reg;
    logic                    m_tvalid_reg;
    logic [M_TDATA_W-1:0]    m_tdata_reg;

    // Step position store; an entry's value is only used while its running bit is set.
    logic [STEP_W-1:0]       step_mem [MEM_DEPTH];
    logic [STEP_W-1:0]       rd_data_reg;
    logic                    mem_we;
    logic                    mem_re;
    logic [MEM_ADDR_W-1:0]   mem_waddr;
    logic [MEM_ADDR_W-1:0]   mem_raddr;
    logic [STEP_W-1:0]       mem_wdata;

    seq_mask_t               cur_mask;
    logic [SEQ_W-1:0]        cur_prio;
    seq_mask_t               run_mask;
    logic [ENTRY_W-1:0]      entry;
    logic [ACT_W-1:0]        act;
    logic                    entry_level;
    logic                    scan_last;
    logic                    out_free;

    // Writes one LED bit; LEDs beyond the output width have no level bit.
    function automatic logic [LEVEL_W-1:0] put_level(logic [LEVEL_W-1:0] lv,
                                                    logic [LED_IDX_W-1:0] led,
                                                    logic on);
        logic [LEVEL_W-1:0] result;
        result = lv;
        if (int'(led) < LEVEL_W) begin
            result[LEVEL_IDX_W'(led)] = on;
        end
        return result;
    endfunction

    // Decode of the current LED, the popped command and the fetched step.
    always_comb begin
        cur_mask    = running_reg[cur_led_reg];
        cur_prio    = first_running(cur_mask);
        run_mask    = running_reg[pop_cmd.led];
        run_mask[SEQ_IDX_W'(pop_cmd.seq)] = 1'b1;
        entry       = rom_read(seq_reg, rd_data_reg);
        act         = entry[ACT_W-1:0];
        entry_level = entry[ENTRY_W-1];
    end

    assign scan_last = (cur_led_reg == LAST_LED);
    assign out_free  = !m_tvalid_reg || m_tready;
    assign pop       = (state_reg == ST_IDLE) && !fifo_empty;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Store port control: a run resets the step index, executed steps advance it, a loop step returns it to zero.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = MEM_ADDR_W'({pop_cmd.led, pop_cmd.seq});
        mem_wdata = '0;
        mem_re    = (state_reg == ST_EX_SEL);
        mem_raddr = MEM_ADDR_W'({cur_led_reg, cur_prio});
        if (pop && (pop_cmd.kind == CMD_RUN)) begin
            mem_we = 1'b1;
        end else if (state_reg == ST_EX_RD) begin
            mem_waddr = MEM_ADDR_W'({cur_led_reg, seq_reg});
            if (act == ACT_LOOP) begin
                mem_we = 1'b1;
            end else if (act != ACT_STOP) begin
                mem_we    = 1'b1;
                mem_wdata = rd_data_reg + 1'b1;
            end
        end
    end

    // Step position memory with registered read.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            step_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= step_mem[mem_raddr];
        end
    end

    // Sequencer: command dispatch, tick scan, step execution and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            for (int i = 0; i < NUM_LEDS; i++) begin
                running_reg[i] <= '0;
                wait_reg[i]    <= '0;
            end
            level_reg     <= '0;
            cur_led_reg   <= '0;
            seq_reg       <= '0;
            guard_reg     <= '0;
            tick_mode_reg <= 1'b0;
            acc_reg       <= 1'b0;
            m_tvalid_reg  <= 1'b0;
            m_tdata_reg   <= '0;
        end else begin
            // The output register empties on a transfer unless a new result refills it.
            if (m_tvalid_reg && m_tready && !((state_reg == ST_DONE) && out_free)) begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (pop) begin
                        acc_reg       <= pop_cmd.accepted;
                        tick_mode_reg <= (pop_cmd.kind == CMD_TICK);
                        cur_led_reg   <= (pop_cmd.kind == CMD_TICK) ? '0 : pop_cmd.led;
                        guard_reg     <= '0;
                        unique case (pop_cmd.kind)
                            CMD_TICK: begin
                                state_reg <= ST_TICK_SCAN;
                            end
                            CMD_RUN: begin
                                running_reg[pop_cmd.led] <= run_mask;
                                level_reg <= put_level(level_reg, pop_cmd.led, 1'b0);
                                state_reg <= (first_running(run_mask) == pop_cmd.seq) ?
                                             ST_EX_SEL : ST_DONE;
                            end
                            CMD_STOP: begin
                                running_reg[pop_cmd.led][SEQ_IDX_W'(pop_cmd.seq)] <= 1'b0;
                                level_reg <= put_level(level_reg, pop_cmd.led, 1'b0);
                                state_reg <= ST_EX_SEL;
                            end
                            CMD_NOP: begin
                                state_reg <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_TICK_SCAN: begin
                    // Count down one LED per cycle while no wait expires, and execute on expiry.
                    if (wait_reg[cur_led_reg] != '0) begin
                        wait_reg[cur_led_reg] <= wait_reg[cur_led_reg] - 1'b1;
                    end
                    if (wait_reg[cur_led_reg] == WAIT_W'(1)) begin
                        guard_reg <= '0;
                        state_reg <= ST_EX_SEL;
                    end else if (scan_last) begin
                        state_reg <= ST_DONE;
                    end else begin
                        cur_led_reg <= cur_led_reg + 1'b1;
                    end
                end
                ST_EX_SEL: begin
                    if ((cur_prio == NONE_CODE) || (guard_reg == GUARD_W'(GUARD_LIMIT))) begin
                        wait_reg[cur_led_reg] <= '0;
                        if (tick_mode_reg && !scan_last) begin
                            cur_led_reg <= cur_led_reg + 1'b1;
                            state_reg   <= ST_TICK_SCAN;
                        end else begin
                            state_reg <= ST_DONE;
                        end
                    end else begin
                        seq_reg   <= cur_prio;
                        guard_reg <= guard_reg + 1'b1;
                        state_reg <= ST_EX_RD;
                    end
                end
                ST_EX_RD: begin
                    if (act == ACT_LOOP) begin
                        state_reg <= ST_EX_SEL;
                    end else if (act == ACT_STOP) begin
                        // The stop step's level is written; reselection does not force the LED off.
                        running_reg[cur_led_reg][SEQ_IDX_W'(seq_reg)] <= 1'b0;
                        level_reg <= put_level(level_reg, cur_led_reg, entry_level);
                        state_reg <= ST_EX_SEL;
                    end else begin
                        level_reg <= put_level(level_reg, cur_led_reg, entry_level);
                        if (act != '0) begin
                            wait_reg[cur_led_reg] <= act[WAIT_W-1:0];
                            if (tick_mode_reg && !scan_last) begin
                                cur_led_reg <= cur_led_reg + 1'b1;
                                state_reg   <= ST_TICK_SCAN;
                            end else begin
                                state_reg <= ST_DONE;
                            end
                        end else begin
                            state_reg <= ST_EX_SEL;
                        end
                    end
                end
                ST_DONE: begin
                    // Hand the result to the output register once it is free.
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= M_TDATA_W'({acc_reg, level_reg});
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* rtl/core/lps_checker.sv */
// Port-level checks of the LED pattern sequencer, bound to the top level.
module lps_props (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [lps_pkg::M_TDATA_W-1:0] m_tdata
);
    import lps_pkg::*;

    localparam int MAX_PENDING = FIFO_DEPTH + 2;
    localparam int PEND_W      = $clog2(MAX_PENDING + 1);

    logic [PEND_W-1:0] pending_reg;
    logic              in_xfer;
    logic              out_xfer;

    assign in_xfer  = s_tvalid && s_tready;
    assign out_xfer = m_tvalid && m_tready;

    // Requests taken whose result has not yet been transferred.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pending_reg <= '0;
        end else if (in_xfer && !out_xfer) begin
            pending_reg <= pending_reg + 1'b1;
        end else if (out_xfer && !in_xfer) begin
            pending_reg <= pending_reg - 1'b1;
        end
    end

    // No result is shown right after reset.
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // Every result answers a request.
    a_no_extra: assert property (@(posedge aclk) disable iff (!aresetn)
        out_xfer |-> pending_reg != '0)
        else $error("result without a request");

    // Backpressure only once the queue is full, and never more in flight than its depth plus two.
    a_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> pending_reg >= PEND_W'(FIFO_DEPTH))
        else $error("input stalled with room in the queue");

    a_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pending_reg <= PEND_W'(MAX_PENDING))
        else $error("too many requests in flight");

endmodule

bind led_pattern_priority_sequencer lps_props u_lps_props (.*);
